FILE: hw/rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared widths, event codes and register indexes for the pointer event
// tracker.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 12;
  localparam int BTN_W   = 5;

  // event classes
  localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EV_REL = 5'd2;
  localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

  // codes within a class
  localparam logic [CODE_W-1:0] ABS_X          = 10'h000;
  localparam logic [CODE_W-1:0] ABS_Y          = 10'h001;
  localparam logic [CODE_W-1:0] ABS_PRESSURE   = 10'h018;
  localparam logic [CODE_W-1:0] ABS_MT_PRESS   = 10'h01c;
  localparam logic [CODE_W-1:0] REL_X          = 10'h000;
  localparam logic [CODE_W-1:0] REL_Y          = 10'h001;
  localparam logic [CODE_W-1:0] REL_WHEEL      = 10'h008;
  localparam logic [CODE_W-1:0] KEY_BTN_LEFT   = 10'h110;
  localparam logic [CODE_W-1:0] KEY_BTN_RIGHT  = 10'h111;
  localparam logic [CODE_W-1:0] KEY_BTN_MIDDLE = 10'h112;

  // pressure above this starts a touch
  localparam logic signed [VALUE_W-1:0] TOUCH_THRESHOLD = 32'sd24;

  // button bit positions
  localparam int BTN_LEFT_BIT   = 0;
  localparam int BTN_MIDDLE_BIT = 1;
  localparam int BTN_RIGHT_BIT  = 2;
  localparam int BTN_WHEEL_UP   = 3;
  localparam int BTN_WHEEL_OTH  = 4;

  // register indexes (paddr[2])
  localparam logic REG_SCREEN_MAX_X = 1'b0;
  localparam logic REG_SCREEN_MAX_Y = 1'b1;

  localparam logic [POS_W-1:0] SCREEN_MAX_X_RST = 12'd1023;
  localparam logic [POS_W-1:0] SCREEN_MAX_Y_RST = 12'd767;

endpackage

FILE: hw/rtl/pet_if.sv
// ----------------------------------------------------------------------------
// pet_if
// Valid/ready channels for input events and tracker results.
// ----------------------------------------------------------------------------
interface pet_event_if;
  logic                                 valid;
  logic                                 ready;
  logic [pet_pkg::TYPE_W-1:0]           event_type;
  logic [pet_pkg::CODE_W-1:0]           event_code;
  logic signed [pet_pkg::VALUE_W-1:0]   event_value;
  logic                                 shift_held;

  modport source (output valid, event_type, event_code, event_value, shift_held,
                  input ready);
  modport sink   (input valid, event_type, event_code, event_value, shift_held,
                  output ready);
endinterface

interface pet_result_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [pet_pkg::POS_W-1:0]   pointer_x;
  logic [pet_pkg::POS_W-1:0]   pointer_y;
  logic [pet_pkg::BTN_W-1:0]   button_bits;
  logic [pet_pkg::POS_W-1:0]   dirty_min_x;
  logic [pet_pkg::POS_W-1:0]   dirty_min_y;
  logic [pet_pkg::POS_W-1:0]   dirty_max_x;
  logic [pet_pkg::POS_W-1:0]   dirty_max_y;

  modport source (output valid, accepted, pointer_x, pointer_y, button_bits,
                  dirty_min_x, dirty_min_y, dirty_max_x, dirty_max_y,
                  input ready);
  modport sink   (input valid, accepted, pointer_x, pointer_y, button_bits,
                  dirty_min_x, dirty_min_y, dirty_max_x, dirty_max_y,
                  output ready);
endinterface

FILE: hw/rtl/pointer_event_tracker.sv
// ----------------------------------------------------------------------------
// pointer_event_tracker
// Tracks pointer position, buttons and touch anchor from a stream of input
// events and reports position, buttons and a dirty rectangle per event.
// ----------------------------------------------------------------------------
// One event is taken per clock: the state update and the result are computed
// in the cycle the event transaction is accepted, and the result shows up in
// the output register on the next cycle, so the sustained rate is one event
// per cycle. The input stalls only while the output register holds a result
// that the sink has not taken. Unknown event types or codes give a result
// with accepted low and all other fields zero.
// Screen limits are set over the APB port (0x0: max x, 0x4: max y) and must
// only be written while no event is in flight.
module pointer_event_tracker #(
  parameter int COORD_BITS  = 12,
  parameter int CURSOR_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  pet_event_if.sink                   events,
  pet_result_if.source                results
);
  import pet_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam logic [POS_W:0] CUR_SZ = (POS_W+1)'(CURSOR_SIZE);

  // configuration
  logic [POS_W-1:0] scr_max_x, scr_max_y;
  logic             cfg_wr;

  // tracker state
  logic [POS_W-1:0]   ptr_x, ptr_y;
  logic [BTN_W-1:0]   btn_state;
  logic               touching;
  logic [VALUE_W-1:0] abs_x, abs_y, anchor_abs_x, anchor_abs_y;
  logic [POS_W-1:0]   anchor_ptr_x, anchor_ptr_y;

  logic [POS_W-1:0]   ptr_x_next, ptr_y_next;
  logic [BTN_W-1:0]   btn_state_next;
  logic               touching_next;
  logic [VALUE_W-1:0] abs_x_next, abs_y_next, anchor_abs_x_next, anchor_abs_y_next;
  logic [POS_W-1:0]   anchor_ptr_x_next, anchor_ptr_y_next;

  // result register
  logic             res_valid;
  logic             res_accepted;
  logic [POS_W-1:0] res_ptr_x, res_ptr_y;
  logic [BTN_W-1:0] res_btn;
  logic [POS_W-1:0] res_min_x, res_min_y, res_max_x, res_max_y;

  logic             in_fire;
  logic             ok;
  logic [BTN_W-1:0] rbit;
  logic [POS_W-1:0] hx, hy;
  logic signed [VALUE_W+1:0] nx, ny;
  logic signed [VALUE_W:0]   dx, dy, qx, qy;
  logic [POS_W-1:0] lo_x, lo_y, hi_x, hi_y;
  logic [POS_W:0]   grow_x, grow_y;
  logic [POS_W-1:0] dmin_x, dmin_y, dmax_x, dmax_y;

  // ---------------------------------------------------------------------------
  // APB register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SCREEN_MAX_Y) begin
      prdata[POS_W-1:0] = scr_max_y;
    end else begin
      prdata[POS_W-1:0] = scr_max_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_max_x <= SCREEN_MAX_X_RST;
      scr_max_y <= SCREEN_MAX_Y_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SCREEN_MAX_X) begin
        scr_max_x <= pwdata[POS_W-1:0];
      end else begin
        scr_max_y <= pwdata[POS_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event update
  // ---------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] clamp_pos(logic signed [VALUE_W+1:0] v,
                                                 logic [POS_W-1:0] hi);
    logic [POS_W-1:0] r;
    if (v[VALUE_W+1]) begin
      r = '0;
    end else if (v > $signed({{(VALUE_W+2-POS_W){1'b0}}, hi})) begin
      r = hi;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign events.ready = !res_valid || results.ready;
  assign in_fire      = events.valid && events.ready;

  assign hx = (int'(scr_max_x) > COORD_MAX) ? POS_W'(COORD_MAX) : scr_max_x;
  assign hy = (int'(scr_max_y) > COORD_MAX) ? POS_W'(COORD_MAX) : scr_max_y;

  always_comb begin
    ok                = 1'b1;
    btn_state_next    = btn_state;
    btn_state_next[BTN_WHEEL_UP]  = 1'b0;
    btn_state_next[BTN_WHEEL_OTH] = 1'b0;
    touching_next     = touching;
    abs_x_next        = abs_x;
    abs_y_next        = abs_y;
    anchor_abs_x_next = anchor_abs_x;
    anchor_abs_y_next = anchor_abs_y;
    anchor_ptr_x_next = anchor_ptr_x;
    anchor_ptr_y_next = anchor_ptr_y;
    nx   = $signed({{(VALUE_W+2-POS_W){1'b0}}, ptr_x});
    ny   = $signed({{(VALUE_W+2-POS_W){1'b0}}, ptr_y});
    dx   = '0;
    dy   = '0;
    qx   = '0;
    qy   = '0;
    rbit = '0;

    unique case (events.event_type)
      EV_ABS: begin
        if (events.event_code == ABS_X) begin
          abs_x_next = events.event_value;
        end else if (events.event_code == ABS_Y) begin
          abs_y_next = events.event_value;
        end else if (events.event_code == ABS_PRESSURE ||
                     events.event_code == ABS_MT_PRESS) begin
          if (events.event_value == '0) begin
            touching_next = 1'b0;
          end else if (events.event_value > TOUCH_THRESHOLD) begin
            touching_next     = 1'b1;
            anchor_abs_x_next = abs_x;
            anchor_abs_y_next = abs_y;
            anchor_ptr_x_next = ptr_x;
            anchor_ptr_y_next = ptr_y;
          end
        end else begin
          ok = 1'b0;
        end
        // quarter of finger travel, truncated toward zero
        dx = $signed({abs_x_next[VALUE_W-1], abs_x_next})
           - $signed({anchor_abs_x_next[VALUE_W-1], anchor_abs_x_next});
        dy = $signed({abs_y_next[VALUE_W-1], abs_y_next})
           - $signed({anchor_abs_y_next[VALUE_W-1], anchor_abs_y_next});
        qx = $signed(dx + (dx[VALUE_W] ? (VALUE_W+1)'(3) : (VALUE_W+1)'(0))) >>> 2;
        qy = $signed(dy + (dy[VALUE_W] ? (VALUE_W+1)'(3) : (VALUE_W+1)'(0))) >>> 2;
        if (ok && touching_next) begin
          nx = $signed({{(VALUE_W+2-POS_W){1'b0}}, anchor_ptr_x_next})
             + $signed({qx[VALUE_W], qx});
          ny = $signed({{(VALUE_W+2-POS_W){1'b0}}, anchor_ptr_y_next})
             + $signed({qy[VALUE_W], qy});
        end
      end
      EV_REL: begin
        if (events.event_code == REL_X) begin
          nx = nx + $signed({{2{events.event_value[VALUE_W-1]}}, events.event_value});
        end else if (events.event_code == REL_Y) begin
          ny = ny + $signed({{2{events.event_value[VALUE_W-1]}}, events.event_value});
        end else if (events.event_code == REL_WHEEL) begin
          if (events.event_value == VALUE_W'(1)) begin
            btn_state_next[BTN_WHEEL_UP] = 1'b1;
          end else begin
            btn_state_next[BTN_WHEEL_OTH] = 1'b1;
          end
        end else begin
          ok = 1'b0;
        end
      end
      EV_KEY: begin
        // shift turns the right button into the middle bit
        rbit[events.shift_held ? BTN_MIDDLE_BIT : BTN_RIGHT_BIT] = 1'b1;
        if (events.event_code == KEY_BTN_LEFT) begin
          rbit = '0;
          rbit[BTN_LEFT_BIT] = 1'b1;
        end else if (events.event_code == KEY_BTN_MIDDLE) begin
          rbit = '0;
          rbit[BTN_MIDDLE_BIT] = 1'b1;
        end else if (events.event_code != KEY_BTN_RIGHT) begin
          ok = 1'b0;
        end
        if (ok) begin
          if (events.event_value == VALUE_W'(1)) begin
            btn_state_next = btn_state_next | rbit;
          end else begin
            btn_state_next = btn_state_next & ~rbit;
          end
        end
      end
      default: ok = 1'b0;
    endcase

    if (ok) begin
      ptr_x_next = clamp_pos(nx, hx);
      ptr_y_next = clamp_pos(ny, hy);
    end else begin
      ptr_x_next        = ptr_x;
      ptr_y_next        = ptr_y;
      touching_next     = touching;
      abs_x_next        = abs_x;
      abs_y_next        = abs_y;
      anchor_abs_x_next = anchor_abs_x;
      anchor_abs_y_next = anchor_abs_y;
      anchor_ptr_x_next = anchor_ptr_x;
      anchor_ptr_y_next = anchor_ptr_y;
    end
  end

  // dirty rectangle: old and new cursor squares, clipped to the screen
  always_comb begin
    lo_x   = (ptr_x_next < ptr_x) ? ptr_x_next : ptr_x;
    lo_y   = (ptr_y_next < ptr_y) ? ptr_y_next : ptr_y;
    hi_x   = (ptr_x_next > ptr_x) ? ptr_x_next : ptr_x;
    hi_y   = (ptr_y_next > ptr_y) ? ptr_y_next : ptr_y;
    dmin_x = ({1'b0, lo_x} >= CUR_SZ) ? POS_W'({1'b0, lo_x} - CUR_SZ) : '0;
    dmin_y = ({1'b0, lo_y} >= CUR_SZ) ? POS_W'({1'b0, lo_y} - CUR_SZ) : '0;
    grow_x = {1'b0, hi_x} + CUR_SZ;
    grow_y = {1'b0, hi_y} + CUR_SZ;
    dmax_x = (grow_x > {1'b0, scr_max_x}) ? scr_max_x : grow_x[POS_W-1:0];
    dmax_y = (grow_y > {1'b0, scr_max_y}) ? scr_max_y : grow_y[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_x        <= '0;
      ptr_y        <= '0;
      btn_state    <= '0;
      touching     <= 1'b0;
      abs_x        <= '0;
      abs_y        <= '0;
      anchor_abs_x <= '0;
      anchor_abs_y <= '0;
      anchor_ptr_x <= '0;
      anchor_ptr_y <= '0;
    end else if (in_fire) begin
      ptr_x        <= ptr_x_next;
      ptr_y        <= ptr_y_next;
      btn_state    <= btn_state_next;
      touching     <= touching_next;
      abs_x        <= abs_x_next;
      abs_y        <= abs_y_next;
      anchor_abs_x <= anchor_abs_x_next;
      anchor_abs_y <= anchor_abs_y_next;
      anchor_ptr_x <= anchor_ptr_x_next;
      anchor_ptr_y <= anchor_ptr_y_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_accepted <= ok;
      res_ptr_x    <= ok ? ptr_x_next : '0;
      res_ptr_y    <= ok ? ptr_y_next : '0;
      res_btn      <= ok ? btn_state_next : '0;
      res_min_x    <= ok ? dmin_x : '0;
      res_min_y    <= ok ? dmin_y : '0;
      res_max_x    <= ok ? dmax_x : '0;
      res_max_y    <= ok ? dmax_y : '0;
    end
  end

  assign results.valid       = res_valid;
  assign results.accepted    = res_accepted;
  assign results.pointer_x   = res_ptr_x;
  assign results.pointer_y   = res_ptr_y;
  assign results.button_bits = res_btn;
  assign results.dirty_min_x = res_min_x;
  assign results.dirty_min_y = res_min_y;
  assign results.dirty_max_x = res_max_x;
  assign results.dirty_max_y = res_max_y;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> results.valid)
    else $error("accepted event produced no result");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.accepted) |->
      (results.pointer_x == '0 && results.pointer_y == '0 &&
       results.button_bits == '0 && results.dirty_max_x == '0 &&
       results.dirty_max_y == '0))
    else $error("rejected event reported nonzero fields");

  a_wheel_excl: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.button_bits[BTN_WHEEL_UP] &&
                        results.button_bits[BTN_WHEEL_OTH]))
    else $error("both wheel bits set");

  a_ptr_on_screen: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.accepted) |->
      (results.pointer_x <= scr_max_x && results.pointer_y <= scr_max_y))
    else $error("pointer outside screen");

endmodule

FILE: tb/pointer_event_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_event_tracker_tb
// Drives key, relative and absolute events, touch gestures and noise into
// the tracker under several screen limits. A scoreboard keeps its own copy
// of the pointer state and checks every result field by field.
// ----------------------------------------------------------------------------
import pet_pkg::*;

typedef struct {
  logic [TYPE_W-1:0]         etype;
  logic [CODE_W-1:0]         code;
  logic signed [VALUE_W-1:0] value;
  logic                      shift;
} pet_event_t;

typedef struct {
  logic              accepted;
  logic [POS_W-1:0]  px;
  logic [POS_W-1:0]  py;
  logic [BTN_W-1:0]  buttons;
  logic [POS_W-1:0]  min_x;
  logic [POS_W-1:0]  min_y;
  logic [POS_W-1:0]  max_x;
  logic [POS_W-1:0]  max_y;
} tracker_report_t;

class pointer_scoreboard;
  localparam longint COORD_TOP = (longint'(1) << POS_W) - 1;
  localparam longint CURSOR_SQ = 16;

  logic [POS_W-1:0]          lim_x, lim_y;
  logic [POS_W-1:0]          pos_x, pos_y;
  logic [BTN_W-1:0]          buttons;
  bit                        touch_on;
  logic signed [VALUE_W-1:0] last_abs_x, last_abs_y;
  logic signed [VALUE_W-1:0] anchor_abs_x, anchor_abs_y;
  logic [POS_W-1:0]          anchor_pos_x, anchor_pos_y;
  tracker_report_t           reports_due[$];
  int                        errors;

  function new();
    lim_x = SCREEN_MAX_X_RST;
    lim_y = SCREEN_MAX_Y_RST;
    pos_x = '0;
    pos_y = '0;
    buttons = '0;
    touch_on = 0;
    last_abs_x = '0;
    last_abs_y = '0;
    anchor_abs_x = '0;
    anchor_abs_y = '0;
    anchor_pos_x = '0;
    anchor_pos_y = '0;
    errors = 0;
  endfunction

  function void set_limit(logic idx, logic [POS_W-1:0] v);
    if (idx == REG_SCREEN_MAX_X) lim_x = v;
    else lim_y = v;
  endfunction

  function int outstanding();
    return reports_due.size();
  endfunction

  function logic [POS_W-1:0] clamp_coord(longint v, longint hi);
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v[POS_W-1:0];
  endfunction

  // update the pointer state from one accepted event and queue its report
  function void note_event(pet_event_t e);
    tracker_report_t r;
    longint nx, ny, ox, oy, hx, hy, mnx, mny, mxx, mxy;
    bit ok;
    int rbit;
    hx = (longint'(lim_x) < COORD_TOP) ? longint'(lim_x) : COORD_TOP;
    hy = (longint'(lim_y) < COORD_TOP) ? longint'(lim_y) : COORD_TOP;
    nx = pos_x;
    ny = pos_y;
    ox = nx;
    oy = ny;
    ok = 1;
    // wheel bits only live for one event, rejected ones included
    buttons[BTN_WHEEL_UP] = 1'b0;
    buttons[BTN_WHEEL_OTH] = 1'b0;
    if (e.etype == EV_ABS) begin
      if (e.code == ABS_X) last_abs_x = e.value;
      else if (e.code == ABS_Y) last_abs_y = e.value;
      else if (e.code == ABS_PRESSURE || e.code == ABS_MT_PRESS) begin
        if (e.value == 0) touch_on = 0;
        else if (e.value > TOUCH_THRESHOLD) begin
          touch_on = 1;
          anchor_abs_x = last_abs_x;
          anchor_abs_y = last_abs_y;
          anchor_pos_x = pos_x;
          anchor_pos_y = pos_y;
        end
      end else ok = 0;
      if (ok && touch_on) begin
        nx = longint'(anchor_pos_x) + (longint'(last_abs_x) - longint'(anchor_abs_x)) / 4;
        ny = longint'(anchor_pos_y) + (longint'(last_abs_y) - longint'(anchor_abs_y)) / 4;
      end
    end else if (e.etype == EV_REL) begin
      if (e.code == REL_X) nx += longint'(e.value);
      else if (e.code == REL_Y) ny += longint'(e.value);
      else if (e.code == REL_WHEEL) begin
        if (e.value == 1) buttons[BTN_WHEEL_UP] = 1'b1;
        else buttons[BTN_WHEEL_OTH] = 1'b1;
      end else ok = 0;
    end else if (e.etype == EV_KEY) begin
      rbit = e.shift ? BTN_MIDDLE_BIT : BTN_RIGHT_BIT;
      if (e.code == KEY_BTN_LEFT) rbit = BTN_LEFT_BIT;
      else if (e.code == KEY_BTN_MIDDLE) rbit = BTN_MIDDLE_BIT;
      else if (e.code != KEY_BTN_RIGHT) ok = 0;
      if (ok) buttons[rbit] = (e.value == 1);
    end else ok = 0;

    if (!ok) begin
      r = '{default: '0};
      reports_due.push_back(r);
      return;
    end

    pos_x = clamp_coord(nx, hx);
    pos_y = clamp_coord(ny, hy);
    mnx = ((longint'(pos_x) < ox) ? longint'(pos_x) : ox) - CURSOR_SQ;
    mny = ((longint'(pos_y) < oy) ? longint'(pos_y) : oy) - CURSOR_SQ;
    mxx = ((longint'(pos_x) > ox) ? longint'(pos_x) : ox) + CURSOR_SQ;
    mxy = ((longint'(pos_y) > oy) ? longint'(pos_y) : oy) + CURSOR_SQ;
    if (mnx < 0) mnx = 0;
    if (mny < 0) mny = 0;
    if (mxx > longint'(lim_x)) mxx = lim_x;
    if (mxy > longint'(lim_y)) mxy = lim_y;
    r.accepted = 1'b1;
    r.px = pos_x;
    r.py = pos_y;
    r.buttons = buttons;
    r.min_x = mnx[POS_W-1:0];
    r.min_y = mny[POS_W-1:0];
    r.max_x = mxx[POS_W-1:0];
    r.max_y = mxy[POS_W-1:0];
    reports_due.push_back(r);
  endfunction

  function void compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      errors++;
    end
  endfunction

  function void check_report(tracker_report_t got);
    tracker_report_t want;
    if (reports_due.size() == 0) begin
      $error("result transaction with no event outstanding");
      errors++;
      return;
    end
    want = reports_due.pop_front();
    compare_field("accepted", want.accepted, got.accepted);
    compare_field("pointer_x", want.px, got.px);
    compare_field("pointer_y", want.py, got.py);
    compare_field("button_bits", want.buttons, got.buttons);
    compare_field("dirty_min_x", want.min_x, got.min_x);
    compare_field("dirty_min_y", want.min_y, got.min_y);
    compare_field("dirty_max_x", want.max_x, got.max_x);
    compare_field("dirty_max_y", want.max_y, got.max_y);
  endfunction
endclass

module pointer_event_tracker_tb;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PARK_CYCLES  = 80;

  // unknown event types, and unknown codes within known classes, for the reject paths
  localparam logic [TYPE_W-1:0] EV_UNUSED   = 5'd0;
  localparam logic [TYPE_W-1:0] EV_SPARE    = 5'd4;
  localparam logic [TYPE_W-1:0] EV_TOP      = 5'd31;
  localparam logic [CODE_W-1:0] REL_UNKNOWN = 10'h002;
  localparam logic [CODE_W-1:0] ABS_UNKNOWN = 10'h005;
  localparam logic [CODE_W-1:0] KEY_UNKNOWN = 10'h113;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pet_event_if  ev_if();
  pet_result_if res_if();

  pointer_event_tracker i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .events  (ev_if),
    .results (res_if)
  );

  pointer_scoreboard sb = new();

  bit calm;          // no idling on either side while set
  bit park_results;  // asks the result side for one long hold-off
  int park_left;
  int items_sent;
  int cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("pointer_event_tracker_tb NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    park_left = 0;
    forever begin
      @(negedge clk);
      if (park_results) begin
        park_left = PARK_CYCLES;
        park_results = 0;
      end
      if (park_left > 0) begin
        park_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    tracker_report_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.accepted = res_if.accepted;
      got.px = res_if.pointer_x;
      got.py = res_if.pointer_y;
      got.buttons = res_if.button_bits;
      got.min_x = res_if.dirty_min_x;
      got.min_y = res_if.dirty_min_y;
      got.max_x = res_if.dirty_max_x;
      got.max_y = res_if.dirty_max_y;
      sb.check_report(got);
    end
  end

  function automatic pet_event_t mk(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                    logic signed [VALUE_W-1:0] v, logic s);
    pet_event_t e;
    e.etype = t;
    e.code = c;
    e.value = v;
    e.shift = s;
    return e;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_event(pet_event_t e);
    if (!calm && $urandom_range(99) < 6) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    ev_if.valid <= 1'b1;
    ev_if.event_type <= e.etype;
    ev_if.event_code <= e.code;
    ev_if.event_value <= e.value;
    ev_if.shift_held <= e.shift;
    do @(posedge clk); while (!ev_if.ready);
    sb.note_event(e);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_events();
    ev_if.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_screen(logic [POS_W-1:0] mx, logic [POS_W-1:0] my);
    logic [31:0] rd;
    drain_events();
    repeat (3) @(negedge clk);
    apb_access(1'b1, REG_SCREEN_MAX_X, {20'd0, mx}, rd);
    apb_access(1'b1, REG_SCREEN_MAX_Y, {20'd0, my}, rd);
    sb.set_limit(REG_SCREEN_MAX_X, mx);
    sb.set_limit(REG_SCREEN_MAX_Y, my);
    apb_access(1'b0, REG_SCREEN_MAX_X, '0, rd);
    if (rd[POS_W-1:0] != mx) begin
      $error("screen_max_x readback: expected 0x%0h, got 0x%0h", mx, rd[POS_W-1:0]);
      sb.errors++;
    end
    apb_access(1'b0, REG_SCREEN_MAX_Y, '0, rd);
    if (rd[POS_W-1:0] != my) begin
      $error("screen_max_y readback: expected 0x%0h, got 0x%0h", my, rd[POS_W-1:0]);
      sb.errors++;
    end
  endtask

  function automatic pet_event_t rand_event();
    int sel;
    logic [CODE_W-1:0] c;
    logic signed [VALUE_W-1:0] v;
    logic s;
    sel = $urandom_range(99);
    s = 1'($urandom_range(1));
    if (sel < 8) begin
      return mk(TYPE_W'($urandom), CODE_W'($urandom), $urandom, s);
    end else if (sel < 14) begin
      // known class, mostly unknown code
      case ($urandom_range(2))
        0: return mk(EV_KEY, CODE_W'($urandom), $urandom, s);
        1: return mk(EV_REL, CODE_W'($urandom), $urandom, s);
        default: return mk(EV_ABS, CODE_W'($urandom), $urandom, s);
      endcase
    end else if (sel < 45) begin
      c = $urandom_range(1) ? REL_X : REL_Y;
      case ($urandom_range(9))
        0: v = $urandom;
        1, 2: v = int'($urandom_range(4000)) - 2000;
        default: v = int'($urandom_range(80)) - 40;
      endcase
      return mk(EV_REL, c, v, s);
    end else if (sel < 55) begin
      case ($urandom_range(3))
        0, 1: v = 1;
        2: v = -1;
        default: v = $urandom;
      endcase
      return mk(EV_REL, REL_WHEEL, v, s);
    end else if (sel < 80) begin
      case ($urandom_range(2))
        0: c = KEY_BTN_LEFT;
        1: c = KEY_BTN_RIGHT;
        default: c = KEY_BTN_MIDDLE;
      endcase
      case ($urandom_range(4))
        0, 1: v = 1;
        2, 3: v = 0;
        default: v = $urandom;
      endcase
      return mk(EV_KEY, c, v, s);
    end else begin
      case ($urandom_range(3))
        0: return mk(EV_ABS, ABS_X, int'($urandom_range(8000)), s);
        1: return mk(EV_ABS, ABS_Y, int'($urandom_range(8000)), s);
        2: return mk(EV_ABS, ABS_PRESSURE, int'($urandom_range(60)) - 10, s);
        default: return mk(EV_ABS, ABS_MT_PRESS, $urandom, s);
      endcase
    end
  endfunction

  // press, finger travel with some noise mixed in, then usually a lift
  task automatic send_touch_gesture();
    int gx, gy, steps;
    logic [CODE_W-1:0] pcode;
    pcode = $urandom_range(1) ? ABS_PRESSURE : ABS_MT_PRESS;
    if ($urandom_range(19) == 0) begin
      gx = $urandom;
      gy = $urandom;
    end else begin
      gx = $urandom_range(8000);
      gy = $urandom_range(8000);
    end
    send_event(mk(EV_ABS, ABS_X, gx, 1'($urandom_range(1))));
    send_event(mk(EV_ABS, ABS_Y, gy, 1'($urandom_range(1))));
    send_event(mk(EV_ABS, pcode, int'($urandom_range(25, 400)), 1'($urandom_range(1))));
    steps = $urandom_range(2, 10);
    repeat (steps) begin
      case ($urandom_range(9))
        0: send_event(mk(EV_ABS, pcode, int'($urandom_range(24)) - 1000 *
                         int'($urandom_range(1)), 1'($urandom_range(1))));
        1: send_event(rand_event());
        default: begin
          if ($urandom_range(1)) begin
            gx += int'($urandom_range(400)) - 200;
            if ($urandom_range(29) == 0) gx = $urandom;
            send_event(mk(EV_ABS, ABS_X, gx, 1'($urandom_range(1))));
          end else begin
            gy += int'($urandom_range(400)) - 200;
            if ($urandom_range(29) == 0) gy = $urandom;
            send_event(mk(EV_ABS, ABS_Y, gy, 1'($urandom_range(1))));
          end
        end
      endcase
    end
    if ($urandom_range(3) != 0) send_event(mk(EV_ABS, pcode, 0, 1'($urandom_range(1))));
  endtask

  task automatic run_random(int count, bit do_park, bit do_pause);
    int start;
    bit parked, paused;
    start = items_sent;
    parked = 0;
    paused = 0;
    while (items_sent < start + count) begin
      if (do_pause && !paused && items_sent >= start + count / 3) begin
        paused = 1;
        drain_events();
      end
      if (do_park && !parked && items_sent >= start + count / 2) begin
        parked = 1;
        park_results = 1;
      end
      if ($urandom_range(99) < 25) send_touch_gesture();
      else send_event(rand_event());
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ev_if.valid = 1'b0;
    ev_if.event_type = '0;
    ev_if.event_code = '0;
    ev_if.event_value = '0;
    ev_if.shift_held = 1'b0;
    calm = 0;
    park_results = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset screen limits
    send_event(mk(EV_REL, REL_X, 5, 1'b0));
    send_event(mk(EV_REL, REL_Y, 7, 1'b0));
    send_event(mk(EV_REL, REL_X, -100, 1'b0));
    send_event(mk(EV_REL, REL_X, 32'sh7fffffff, 1'b1));
    send_event(mk(EV_REL, REL_Y, 32'sh80000000, 1'b0));
    send_event(mk(EV_REL, REL_WHEEL, 1, 1'b0));
    send_event(mk(EV_REL, REL_WHEEL, -1, 1'b0));
    send_event(mk(EV_KEY, KEY_BTN_LEFT, 1, 1'b0));
    send_event(mk(EV_KEY, KEY_BTN_RIGHT, 1, 1'b0));
    send_event(mk(EV_KEY, KEY_BTN_RIGHT, 1, 1'b1));
    send_event(mk(EV_KEY, KEY_BTN_MIDDLE, 2, 1'b0));
    send_event(mk(EV_KEY, KEY_BTN_LEFT, 0, 1'b1));
    send_event(mk(EV_UNUSED, REL_X, 3, 1'b0));
    send_event(mk(EV_SPARE, REL_X, 3, 1'b0));
    send_event(mk(EV_TOP, 10'h3ff, 32'shffffffff, 1'b1));
    send_event(mk(EV_REL, REL_UNKNOWN, 9, 1'b0));
    send_event(mk(EV_KEY, KEY_UNKNOWN, 1, 1'b0));
    send_event(mk(EV_ABS, ABS_UNKNOWN, 1, 1'b0));
    send_event(mk(EV_ABS, ABS_X, 400, 1'b0));
    send_event(mk(EV_ABS, ABS_Y, 300, 1'b0));
    send_event(mk(EV_ABS, ABS_PRESSURE, 25, 1'b0));
    send_event(mk(EV_ABS, ABS_X, 483, 1'b0));
    send_event(mk(EV_ABS, ABS_Y, 197, 1'b0));
    send_event(mk(EV_ABS, ABS_PRESSURE, 24, 1'b0));
    send_event(mk(EV_ABS, ABS_MT_PRESS, -5, 1'b0));
    send_event(mk(EV_ABS, ABS_X, 32'sh80000000, 1'b0));
    send_event(mk(EV_ABS, ABS_MT_PRESS, 0, 1'b0));
    send_event(mk(EV_ABS, ABS_X, 100, 1'b0));

    set_screen(12'd4095, 12'd4095);
    run_random(350, 1'b1, 1'b1);
    set_screen(12'd0, 12'd0);
    run_random(100, 1'b0, 1'b0);
    set_screen(12'd100, 12'd50);
    run_random(250, 1'b0, 1'b0);
    set_screen(POS_W'($urandom), POS_W'($urandom));
    calm = 1;
    run_random(150, 1'b0, 1'b0);
    calm = 0;
    run_random(150, 1'b0, 1'b0);
    set_screen(SCREEN_MAX_X_RST, SCREEN_MAX_Y_RST);
    run_random(200, 1'b0, 1'b0);

    drain_events();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("pointer_event_tracker_tb OK");
    end else begin
      $display("pointer_event_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
